/* rtl/lcg_pkg.sv */
`default_nettype none
// ============================================================================
// lcg_pkg
// Shared types, constants and tables for the long count to Gregorian core.
// ============================================================================
package lcg_pkg;

   // Width of the running day offset; covers every digit pattern of the inputs.
   localparam int unsigned OffsetWidth = 22;
   // Internal year width; holds years past the 13-bit output field.
   localparam int unsigned YearWidth   = 14;

   localparam int unsigned YearOutWidth  = 13;
   localparam int unsigned MonthWidth    = 4;
   localparam int unsigned DayWidth      = 5;
   localparam int unsigned DigitWidth    = 5;
   localparam int unsigned NumDigits     = 5;
   localparam int unsigned DigitIdxWidth = 3;
   localparam int unsigned WeightWidth   = 18;

   localparam logic [YearOutWidth-1:0] EPOCH_YEAR = 13'd2012;
   localparam logic [DayWidth-1:0]     EPOCH_DAY  = 5'd21;
   // Days left in December of the epoch year, counting the epoch day itself.
   localparam logic [OffsetWidth-1:0]  EPOCH_TAIL = 22'd11;
   localparam logic [YearWidth-1:0]    FIRST_YEAR = 14'd2013;
   // First full year modulo 100 and modulo 400.
   localparam logic [6:0]              FIRST_Y100 = 7'd13;
   localparam logic [8:0]              FIRST_Y400 = 9'd13;
   localparam logic [YearWidth-1:0]    YEAR_MAX   = 14'd8191;
   localparam logic [OffsetWidth-1:0]  YEAR_DAYS  = 22'd365;

   localparam logic [MonthWidth-1:0]   MONTH_JAN  = 4'd1;
   localparam logic [MonthWidth-1:0]   MONTH_FEB  = 4'd2;
   localparam logic [MonthWidth-1:0]   MONTH_DEC  = 4'd12;

   // Control word from the sequencer to the year tracker.
   typedef struct packed {
      logic load;
      logic step;
   } lcg_year_ctl_type;

   // Mixed-radix weight of one long count digit, most significant first.
   function automatic logic [WeightWidth-1:0] digit_weight(
      input logic [DigitIdxWidth-1:0] idx
   );
      logic [WeightWidth-1:0] w;
      begin
         case (idx)
            3'd0:    w = 18'd144000;
            3'd1:    w = 18'd7200;
            3'd2:    w = 18'd360;
            3'd3:    w = 18'd20;
            default: w = 18'd1;
         endcase
         return w;
      end
   endfunction

   // Length of a month (1 is January), with a leap February.
   function automatic logic [OffsetWidth-1:0] month_days(
      input logic [MonthWidth-1:0] mon,
      input logic                  leap
   );
      logic [OffsetWidth-1:0] d;
      begin
         case (mon)
            MONTH_FEB:                  d = leap ? 22'd29 : 22'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    d = 22'd30;
            default:                    d = 22'd31;
         endcase
         return d;
      end
   endfunction

endpackage
`default_nettype wire

/* rtl/lcg_if.sv */
`default_nettype none
// ============================================================================
// lcg_req_if / lcg_rsp_if
// Valid/ready channels for long count words in and calendar date words out.
// ============================================================================
interface lcg_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] baktun;
   logic [4:0] katun;
   logic [4:0] tun;
   logic [4:0] uinal;
   logic [4:0] kin;

   modport source (output valid, output baktun, output katun, output tun,
                   output uinal, output kin, input ready);
   modport sink   (input valid, input baktun, input katun, input tun,
                   input uinal, input kin, output ready);
endinterface

interface lcg_rsp_if;
   logic        valid;
   logic        ready;
   logic [12:0] year;
   logic [3:0]  month_number;
   logic [4:0]  day_of_month;

   modport source (output valid, output year, output month_number,
                   output day_of_month, input ready);
   modport sink   (input valid, input year, input month_number,
                   input day_of_month, output ready);
endinterface
`default_nettype wire

/* rtl/long_count_to_gregorian_core.sv */
`default_nettype none
// ============================================================================
// long_count_to_gregorian_core
// Converts a Maya long count word to a Gregorian year, month and day.
// ============================================================================
// Usage:
//   req_ch carries a long count word (baktun, katun, tun, uinal, kin); it is
//   taken when valid and ready are both high. rsp_ch returns one date word
//   (year, month_number, day_of_month) for every request word.
//   The block works on one word at a time and holds req_ch.ready low while
//   busy. After a word is accepted, the sequencer accumulates the day offset,
//   takes off the rest of December 2012, then drops one whole year at a time
//   from 2013 on and one whole month at a time in the final year; dates in
//   December 2012 skip the year and month walk. req_ch.ready returns high
//   as the result is loaded into the output register. The year walk through
//   one shared adder/subtractor sets the conversion time; the offset is
//   accumulated digit by digit, most significant first.
//   The date word sits in an output register; if rsp_ch is stalled the
//   finished result waits there and a following result waits in the last
//   sequencer step until the register frees up. Years above 8191 saturate.
//   Reset (synchronous, active high) returns the sequencer to idle and drops
//   rsp_ch.valid; no storage needs clearing.
// ============================================================================
module long_count_to_gregorian_core (
   input  wire logic clock,
   input  wire logic reset,
   lcg_req_if.sink   req_ch,
   lcg_rsp_if.source rsp_ch
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_EPOCH,
      ST_YEAR,
      ST_MONTH,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic [lcg_pkg::DigitWidth-1:0]    digit_ff [lcg_pkg::NumDigits];
   logic [lcg_pkg::DigitWidth-1:0]    digit_in [lcg_pkg::NumDigits];
   logic [lcg_pkg::DigitIdxWidth-1:0] idx_ff, idx_in;
   logic [lcg_pkg::OffsetWidth-1:0]   offset_ff, offset_in;
   logic [lcg_pkg::MonthWidth-1:0]    mon_ff, mon_in;
   logic                              short_ff, short_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [lcg_pkg::YearOutWidth-1:0]   rsp_year_ff, rsp_year_in;
   logic [lcg_pkg::MonthWidth-1:0]     rsp_month_ff, rsp_month_in;
   logic [lcg_pkg::DayWidth-1:0]       rsp_day_ff, rsp_day_in;

   logic                               op_sub;
   logic [lcg_pkg::OffsetWidth-1:0]    op_b;
   logic [lcg_pkg::OffsetWidth-1:0]    unit_result;
   logic                               unit_carry;
   logic [lcg_pkg::DigitWidth+lcg_pkg::WeightWidth-1:0] product;

   lcg_pkg::lcg_year_ctl_type          year_ctl;
   logic [lcg_pkg::YearWidth-1:0]      track_year;
   logic                               track_leap;
   logic [lcg_pkg::YearOutWidth-1:0]   year_sat;

   // Shared arithmetic unit.
   lcg_addsub u_addsub (
      .op_sub (op_sub),
      .a      (offset_ff),
      .b      (op_b),
      .result (unit_result),
      .carry  (unit_carry)
   );

   // Year counter and leap rule.
   lcg_year_track u_year_track (
      .clock (clock),
      .ctl   (year_ctl),
      .year  (track_year),
      .leap  (track_leap)
   );

   // One digit times its weight per accumulate step.
   assign product = digit_ff[idx_ff] * lcg_pkg::digit_weight(idx_ff);

   // Clamp the year to the output field.
   assign year_sat = (track_year > lcg_pkg::YEAR_MAX)
                   ? lcg_pkg::YEAR_MAX[lcg_pkg::YearOutWidth-1:0]
                   : track_year[lcg_pkg::YearOutWidth-1:0];

   // Sequencer: next state, operand selection and output word.
   always_comb begin
      state_in      = state_ff;
      digit_in      = digit_ff;
      idx_in        = idx_ff;
      offset_in     = offset_ff;
      mon_in        = mon_ff;
      short_in      = short_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_year_in   = rsp_year_ff;
      rsp_month_in  = rsp_month_ff;
      rsp_day_in    = rsp_day_ff;
      op_sub        = 1'b1;
      op_b          = lcg_pkg::EPOCH_TAIL;
      year_ctl      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               digit_in[0] = {1'b0, req_ch.baktun};
               digit_in[1] = req_ch.katun;
               digit_in[2] = req_ch.tun;
               digit_in[3] = req_ch.uinal;
               digit_in[4] = req_ch.kin;
               idx_in      = '0;
               offset_in   = '0;
               state_in    = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            op_sub    = 1'b0;
            op_b      = product[lcg_pkg::OffsetWidth-1:0];
            offset_in = unit_result;
            idx_in    = idx_ff + 3'd1;
            if (idx_ff == 3'(lcg_pkg::NumDigits - 1)) begin
               state_in = ST_EPOCH;
            end
         end
         ST_EPOCH: begin
            // Finish the epoch December first; past it, start at January 2013.
            op_b = lcg_pkg::EPOCH_TAIL;
            if (unit_carry) begin
               offset_in     = unit_result;
               short_in      = 1'b0;
               mon_in        = lcg_pkg::MONTH_JAN;
               year_ctl.load = 1'b1;
               state_in      = ST_YEAR;
            end else begin
               short_in = 1'b1;
               mon_in   = lcg_pkg::MONTH_DEC;
               state_in = ST_FINISH;
            end
         end
         ST_YEAR: begin
            // Drop one whole year per cycle while the offset covers it.
            op_b = lcg_pkg::YEAR_DAYS + {21'd0, track_leap};
            if (unit_carry) begin
               offset_in     = unit_result;
               year_ctl.step = 1'b1;
            end else begin
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            // Drop one whole month per cycle.
            op_b = lcg_pkg::month_days(mon_ff, track_leap);
            if (unit_carry && (mon_ff != lcg_pkg::MONTH_DEC)) begin
               offset_in = unit_result;
               mon_in    = mon_ff + 4'd1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_month_in = mon_ff;
               if (short_ff) begin
                  rsp_year_in = lcg_pkg::EPOCH_YEAR;
                  rsp_day_in  = lcg_pkg::EPOCH_DAY + offset_ff[lcg_pkg::DayWidth-1:0];
               end else begin
                  rsp_year_in = year_sat;
                  rsp_day_in  = 5'd1 + offset_ff[lcg_pkg::DayWidth-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      digit_ff     <= digit_in;
      idx_ff       <= idx_in;
      offset_ff    <= offset_in;
      mon_ff       <= mon_in;
      short_ff     <= short_in;
      rsp_year_ff  <= rsp_year_in;
      rsp_month_ff <= rsp_month_in;
      rsp_day_ff   <= rsp_day_in;
   end

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.year         = rsp_year_ff;
   assign rsp_ch.month_number = rsp_month_ff;
   assign rsp_ch.day_of_month = rsp_day_ff;

endmodule
`default_nettype wire

/* rtl/lcg_addsub.sv */
`default_nettype none
// ============================================================================
// lcg_addsub
// Shared adder/subtractor on the day offset. In subtract mode the carry
// out is set when a is not below b.
// ============================================================================
module lcg_addsub (
   input  wire logic                            op_sub,
   input  wire logic [lcg_pkg::OffsetWidth-1:0] a,
   input  wire logic [lcg_pkg::OffsetWidth-1:0] b,
   output logic      [lcg_pkg::OffsetWidth-1:0] result,
   output logic                                 carry
);

   logic [lcg_pkg::OffsetWidth-1:0] b_eff;
   logic [lcg_pkg::OffsetWidth:0]   total;

   // Two's complement subtract by inverting b and injecting a carry.
   assign b_eff  = op_sub ? ~b : b;
   assign total  = {1'b0, a} + {1'b0, b_eff}
                 + {{lcg_pkg::OffsetWidth{1'b0}}, op_sub};
   assign result = total[lcg_pkg::OffsetWidth-1:0];
   assign carry  = total[lcg_pkg::OffsetWidth];

endmodule
`default_nettype wire

/* rtl/lcg_year_track.sv */
`default_nettype none
// ============================================================================
// lcg_year_track
// Year counter with running remainders modulo 100 and 400, so the leap
// rule needs no divider.
// ============================================================================
module lcg_year_track (
   input  wire logic                            clock,
   input  wire lcg_pkg::lcg_year_ctl_type       ctl,
   output logic      [lcg_pkg::YearWidth-1:0]   year,
   output logic                                 leap
);

   logic [lcg_pkg::YearWidth-1:0] year_ff, year_in;
   logic [6:0]                    y100_ff, y100_in;
   logic [8:0]                    y400_ff, y400_in;

   // Load the first full year or advance all three counters together.
   always_comb begin
      year_in = year_ff;
      y100_in = y100_ff;
      y400_in = y400_ff;
      if (ctl.load) begin
         year_in = lcg_pkg::FIRST_YEAR;
         y100_in = lcg_pkg::FIRST_Y100;
         y400_in = lcg_pkg::FIRST_Y400;
      end else if (ctl.step) begin
         year_in = year_ff + 14'd1;
         y100_in = (y100_ff == 7'd99)  ? 7'd0 : y100_ff + 7'd1;
         y400_in = (y400_ff == 9'd399) ? 9'd0 : y400_ff + 9'd1;
      end
   end

   always_ff @(posedge clock) begin
      year_ff <= year_in;
      y100_ff <= y100_in;
      y400_ff <= y400_in;
   end

   // Every fourth year, not every hundredth, but every four hundredth.
   assign leap = (y400_ff == 9'd0) || ((y100_ff != 7'd0) && (year_ff[1:0] == 2'd0));
   assign year = year_ff;

endmodule
`default_nettype wire
